// ===== rtl/i2ccd_pkg.sv =====
// Shared constants, types and helper functions for the bus clock divider search.
`default_nettype none
package i2ccd_pkg;

  localparam int RATE_W = 32;
  localparam int WORD_W = 19;
  localparam int CK_W   = 3;
  localparam int DIV_W  = 8;

  localparam logic [RATE_W-1:0] RATE_CAP        = 32'd400000;
  localparam logic [RATE_W-1:0] HALF_DUTY_LIMIT = 32'd100000;
  localparam logic [RATE_W-1:0] MCLK_RESET      = 32'd64000000;
  localparam logic [RATE_W-1:0] DIVISOR_BIAS    = 32'd4;
  localparam logic [RATE_W-1:0] RATE_NONE       = 32'hFFFF_FFFF;

  localparam int DEF_PRESCALE_STEPS = 8;
  localparam int DEF_DIVIDER_LIMIT  = 256;

  // x/3 for x below 1024 as a multiply by a scaled reciprocal.
  localparam logic [10:0] DIV3_MUL   = 11'd683;
  localparam int          DIV3_SHIFT = 11;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [8:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'(DIV3_MUL);
    return p[DIV3_SHIFT+8:DIV3_SHIFT];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/i2ccd_if.sv =====
// Valid/ready channel interfaces for the request and result of the divider search.
`default_nettype none
interface i2ccd_in_if import i2ccd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] target_rate_hz;

  modport source (output valid, output target_rate_hz, input ready);
  modport sink (input valid, input target_rate_hz, output ready);
endinterface

interface i2ccd_out_if import i2ccd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] waveform_word;
  logic [CK_W-1:0]   prescale_exponent;
  logic [DIV_W-1:0]  half_period_divider;
  logic [RATE_W-1:0] achieved_rate_hz;

  modport source (output valid, output waveform_word, output prescale_exponent,
                  output half_period_divider, output achieved_rate_hz, input ready);
  modport sink (input valid, input waveform_word, input prescale_exponent,
                input half_period_divider, input achieved_rate_hz, output ready);
endinterface
`default_nettype wire

// ===== rtl/i2c_clock_divider_search_core.sv =====
// A request first divides half the master clock by the clamped target to find the base,
// then each candidate divider tried takes one pass of the shared 32-bit divider.
// At most three candidates are tried per prescaler exponent.
// Throughput: one request at a time; the core is ready the cycle after a result is loaded,
// and a finished search waits until the output register is free.
// Reset (synchronous, rst_n low) returns the sequencer to idle, drops the output valid
// and sets the master clock register to 64 MHz.
`default_nettype none
module i2c_clock_divider_search_core import i2ccd_pkg::*; #(
  parameter int PRESCALE_STEPS = DEF_PRESCALE_STEPS,
  parameter int DIVIDER_LIMIT  = DEF_DIVIDER_LIMIT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [RATE_W-1:0] cfg_wr_data,
  i2ccd_in_if.sink               in_chan,
  i2ccd_out_if.source            out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE_WAIT, ST_CK_START, ST_LAUNCH, ST_CAND_WAIT, ST_EVAL, ST_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [RATE_W-1:0] mclk_r, mclk_nxt;
  logic [RATE_W-1:0] tgt_r, tgt_nxt;
  logic [RATE_W-1:0] half_r, half_nxt;
  logic [RATE_W-1:0] pre_r, pre_nxt;
  logic [CK_W-1:0]   ck_r, ck_nxt;
  logic [DIV_W-1:0]  d_r, d_nxt;
  logic [RATE_W-1:0] best_err_r, best_err_nxt;
  logic [RATE_W-1:0] best_rate_r, best_rate_nxt;
  logic [CK_W-1:0]   best_ck_r, best_ck_nxt;
  logic [DIV_W-1:0]  best_d_r, best_d_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic [CK_W-1:0]   out_ck_r, out_ck_nxt;
  logic [DIV_W-1:0]  out_d_r, out_d_nxt;
  logic [RATE_W-1:0] out_rate_r, out_rate_nxt;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [RATE_W-1:0] tgt_clamp;
  logic [RATE_W-1:0] start_d;
  logic [RATE_W-1:0] cand_divisor;
  logic [RATE_W-1:0] rate;
  logic [RATE_W-1:0] err;
  logic              improved;
  logic              walk_stop;
  logic              last_ck;
  logic              last_d;
  logic [8:0]        low_part;
  logic [8:0]        high_part;
  logic [WORD_W-1:0] word;

  i2ccd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign tgt_clamp    = (in_chan.target_rate_hz > RATE_CAP) ? RATE_CAP
                                                            : in_chan.target_rate_hz;
  assign start_d      = (pre_r >> ck_r) - 32'd1;
  assign cand_divisor = (RATE_W'(d_r) << ck_r) + DIVISOR_BIAS;
  assign rate         = div_rsp.quotient;
  assign err          = (rate > tgt_r) ? (rate - tgt_r) : (tgt_r - rate);
  assign improved     = err < best_err_r;
  // The walk over dividers ends on an exact improving hit or once the rate drops below target.
  assign walk_stop    = (improved && (rate == tgt_r)) || (rate < tgt_r);
  assign last_ck      = (ck_r == CK_W'(PRESCALE_STEPS - 1));
  assign last_d       = ({1'b0, d_r} == 9'(DIVIDER_LIMIT - 1));

  assign low_part  = div3({best_d_r, 2'b00});
  assign high_part = div3({1'b0, best_d_r, 1'b0});

  always_comb begin
    if (tgt_r <= HALF_DUTY_LIMIT) begin
      word = WORD_W'(best_d_r) | (WORD_W'(best_d_r) << 8) | (WORD_W'(best_ck_r) << 16);
    end else begin
      word = WORD_W'(low_part) | (WORD_W'(high_part) << 8) | (WORD_W'(best_ck_r) << 16);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mclk_nxt      = cfg_wr_en ? cfg_wr_data : mclk_r;
    tgt_nxt       = tgt_r;
    half_nxt      = half_r;
    pre_nxt       = pre_r;
    ck_nxt        = ck_r;
    d_nxt         = d_r;
    best_err_nxt  = best_err_r;
    best_rate_nxt = best_rate_r;
    best_ck_nxt   = best_ck_r;
    best_d_nxt    = best_d_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_word_nxt  = out_word_r;
    out_ck_nxt    = out_ck_r;
    out_d_nxt     = out_d_r;
    out_rate_nxt  = out_rate_r;
    div_req.start    = 1'b0;
    div_req.dividend = half_r;
    div_req.divisor  = cand_divisor;

    case (state_r)
      ST_IDLE: begin
        div_req.dividend = {1'b0, mclk_r[RATE_W-1:1]};
        div_req.divisor  = tgt_clamp;
        if (in_chan.valid) begin
          div_req.start = 1'b1;
          tgt_nxt       = tgt_clamp;
          half_nxt      = {1'b0, mclk_r[RATE_W-1:1]};
          best_err_nxt  = RATE_NONE - tgt_clamp;
          best_rate_nxt = RATE_NONE;
          best_ck_nxt   = '0;
          best_d_nxt    = '0;
          state_nxt     = ST_PRE_WAIT;
        end
      end
      ST_PRE_WAIT: begin
        if (div_rsp.done) begin
          pre_nxt   = div_rsp.quotient - DIVISOR_BIAS;
          ck_nxt    = '0;
          state_nxt = ST_CK_START;
        end
      end
      ST_CK_START: begin
        // A start at or beyond the divider limit (also one that wrapped) yields no candidates for this exponent.
        if (start_d < RATE_W'(DIVIDER_LIMIT)) begin
          d_nxt     = start_d[DIV_W-1:0];
          state_nxt = ST_LAUNCH;
        end else if (last_ck) begin
          state_nxt = ST_FINISH;
        end else begin
          ck_nxt = ck_r + CK_W'(1);
        end
      end
      ST_LAUNCH: begin
        div_req.start = 1'b1;
        state_nxt     = ST_CAND_WAIT;
      end
      ST_CAND_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (improved) begin
          best_err_nxt  = err;
          best_rate_nxt = rate;
          best_ck_nxt   = ck_r;
          best_d_nxt    = d_r;
        end
        if (walk_stop || last_d) begin
          if (last_ck) begin
            state_nxt = ST_FINISH;
          end else begin
            ck_nxt    = ck_r + CK_W'(1);
            state_nxt = ST_CK_START;
          end
        end else begin
          d_nxt     = d_r + DIV_W'(1);
          state_nxt = ST_LAUNCH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = word;
          out_ck_nxt    = best_ck_r;
          out_d_nxt     = best_d_r;
          out_rate_nxt  = best_rate_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mclk_r      <= MCLK_RESET;
      tgt_r       <= '0;
      half_r      <= '0;
      pre_r       <= '0;
      ck_r        <= '0;
      d_r         <= '0;
      best_err_r  <= '0;
      best_rate_r <= '0;
      best_ck_r   <= '0;
      best_d_r    <= '0;
      out_valid_r <= 1'b0;
      out_word_r  <= '0;
      out_ck_r    <= '0;
      out_d_r     <= '0;
      out_rate_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      mclk_r      <= mclk_nxt;
      tgt_r       <= tgt_nxt;
      half_r      <= half_nxt;
      pre_r       <= pre_nxt;
      ck_r        <= ck_nxt;
      d_r         <= d_nxt;
      best_err_r  <= best_err_nxt;
      best_rate_r <= best_rate_nxt;
      best_ck_r   <= best_ck_nxt;
      best_d_r    <= best_d_nxt;
      out_valid_r <= out_valid_nxt;
      out_word_r  <= out_word_nxt;
      out_ck_r    <= out_ck_nxt;
      out_d_r     <= out_d_nxt;
      out_rate_r  <= out_rate_nxt;
    end
  end

  assign in_chan.ready                = (state_r == ST_IDLE);
  assign out_chan.valid               = out_valid_r;
  assign out_chan.waveform_word       = out_word_r;
  assign out_chan.prescale_exponent   = out_ck_r;
  assign out_chan.half_period_divider = out_d_r;
  assign out_chan.achieved_rate_hz    = out_rate_r;

endmodule
`default_nettype wire

// ===== rtl/i2ccd_div.sv =====
// Shared 32-bit restoring divider, one quotient bit per cycle.
`default_nettype none
module i2ccd_div import i2ccd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0] quo_r, quo_nxt;
  logic [RATE_W-1:0] dsr_r, dsr_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [RATE_W:0]   shifted;
  logic [RATE_W:0]   trial;

  // A zero divisor never borrows, so the quotient comes out all ones.
  assign shifted = {rem_r, quo_r[RATE_W-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[RATE_W]) begin
        rem_nxt = shifted[RATE_W-1:0];
        quo_nxt = {quo_r[RATE_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[RATE_W-1:0];
        quo_nxt = {quo_r[RATE_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(RATE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      quo_r  <= '0;
      dsr_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      dsr_r  <= dsr_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/i2ccd_checker.sv =====
// Port-level checks for the divider search core and their binding to it.
`default_nettype none
module i2ccd_checker import i2ccd_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [WORD_W-1:0] out_word,
  input wire logic [CK_W-1:0]   out_ck,
  input wire logic [DIV_W-1:0]  out_d,
  input wire logic [RATE_W-1:0] out_rate
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word) && $stable(out_ck) && $stable(out_d)
                                && $stable(out_rate))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("core still ready right after taking a request");

  a_word_prescale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word[WORD_W-1:16] == out_ck)
    else $error("waveform word prescaler field differs from prescale exponent");

  a_none_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rate == RATE_NONE) |-> (out_ck == '0) && (out_d == '0))
    else $error("no candidate reported but divisors are nonzero");

endmodule

bind i2c_clock_divider_search_core i2ccd_checker u_i2ccd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_word  (out_chan.waveform_word),
  .out_ck    (out_chan.prescale_exponent),
  .out_d     (out_chan.half_period_divider),
  .out_rate  (out_chan.achieved_rate_hz)
);
`default_nettype wire
